// ===== design/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

    // sizes of the ring store and of the datapath words
    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int HALF_W     = 5;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 22;
    localparam int PROD_W     = SUM_W + GAIN_W;
    localparam int FRAC_W     = 8;
    localparam int VALUE_W    = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 2'd2;

    // configuration reset values
    localparam logic [CNT_W-1:0]         RST_POINT_COUNT = CNT_W'(MAX_POINTS);
    localparam logic [HALF_W-1:0]        RST_HALF_WIDTH  = HALF_W'(1);
    localparam logic signed [GAIN_W-1:0] RST_GAIN        = GAIN_W'(256);

    // controller states, one-hot
    typedef enum logic [6:0] {
        S_LOAD   = 7'b0000001,
        S_DS_RD  = 7'b0000010,
        S_DS_ACC = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_ST_RD  = 7'b0100000,
        S_ST_ACC = 7'b1000000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ld_wr;      // store the accepted sample
        logic run_start;  // last sample of a run: clear sum and counters
        logic ds_rd;      // read one sample of the first window
        logic ds_acc;     // add it to the window sum
        logic st_rd;      // read entering and leaving samples
        logic st_acc;     // slide the window
        logic mul;        // scale the window sum
        logic put;        // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_last;  // current sample closes the run
        logic ds_done;    // first window fully summed
        logic st_last;    // current result is the last of the run
        logic out_free;   // output register can take a result
    } t_status;

endpackage

`default_nettype wire

// ===== design/cbc_ctrl.sv =====
`default_nettype none

module cbc_ctrl
    import cbc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_sample_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_sample_stall
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // samples are taken only while loading
    assign o_sample_stall = (r_state != S_LOAD);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_sample_valid) begin
                    o_cmd.ld_wr = 1'b1;
                    if (i_status.load_last) begin
                        o_cmd.run_start = 1'b1;
                        n_state         = S_DS_RD;
                    end
                end
            end
            S_DS_RD: begin
                o_cmd.ds_rd = 1'b1;
                n_state     = S_DS_ACC;
            end
            S_DS_ACC: begin
                o_cmd.ds_acc = 1'b1;
                n_state      = i_status.ds_done ? S_MUL : S_DS_RD;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = i_status.st_last ? S_LOAD : S_ST_RD;
                end
            end
            S_ST_RD: begin
                o_cmd.st_rd = 1'b1;
                n_state     = S_ST_ACC;
            end
            S_ST_ACC: begin
                o_cmd.st_acc = 1'b1;
                n_state      = S_MUL;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/cbc_datapath.sv =====
`default_nettype none

module cbc_datapath
    import cbc_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  wire logic signed [SAMPLE_W-1:0]   i_sample,
    input  wire t_cmd                         i_cmd,
    input  wire logic                         i_result_stall,
    output t_status                           o_status,
    output logic                              o_result_valid,
    output logic signed [VALUE_W-1:0]         o_value,
    output logic                              o_last
);

    // configuration registers
    logic [CNT_W-1:0]         r_point_count;
    logic [HALF_W-1:0]        r_half_width;
    logic signed [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= RST_POINT_COUNT;
            r_half_width  <= RST_HALF_WIDTH;
            r_gain        <= RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POINT_COUNT: r_point_count <= i_cfg_data[CNT_W-1:0];
                CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[HALF_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg_data[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // effective ring size and clamped half width
    logic [CNT_W-1:0]  eff_n;
    logic [CNT_W-1:0]  n_minus1;
    logic [HALF_W-1:0] h_max;
    logic [HALF_W-1:0] eff_h;

    always_comb begin
        if (r_point_count == '0) begin
            eff_n = CNT_W'(1);
        end else if (r_point_count > CNT_W'(MAX_POINTS)) begin
            eff_n = CNT_W'(MAX_POINTS);
        end else begin
            eff_n = r_point_count;
        end
        n_minus1 = eff_n - CNT_W'(1);
        h_max    = HALF_W'(n_minus1 >> 1);
        eff_h    = (r_half_width > h_max) ? h_max : r_half_width;
    end

    // counters: load position, first-window tap, result index
    logic [ADDR_W-1:0] r_load_idx;
    logic [ADDR_W-1:0] r_tap;
    logic [ADDR_W-1:0] r_pos;

    assign o_status.load_last = ({1'b0, r_load_idx} + CNT_W'(1)) >= eff_n;
    assign o_status.ds_done   = (r_tap == {eff_h, 1'b0});
    assign o_status.st_last   = ({1'b0, r_pos} == n_minus1);
    assign o_status.out_free  = !o_result_valid || !i_result_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_idx <= '0;
        end else if (i_cmd.ld_wr) begin
            r_load_idx <= o_status.load_last ? '0 : r_load_idx + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_tap <= '0;
        end else if (i_cmd.ds_acc && !o_status.ds_done) begin
            r_tap <= r_tap + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_pos <= '0;
        end else if (i_cmd.put && !o_status.st_last) begin
            r_pos <= r_pos + ADDR_W'(1);
        end
    end

    // ring addresses, each wrapped by one compare and subtract
    logic [CNT_W-1:0] ds_raw;
    logic [CNT_W-1:0] enter_raw;
    logic [CNT_W-1:0] leave_raw;
    logic [CNT_W-1:0] ds_addr;
    logic [CNT_W-1:0] enter_addr;
    logic [CNT_W-1:0] leave_addr;

    always_comb begin
        ds_raw     = eff_n - CNT_W'(eff_h) + CNT_W'(r_tap);
        enter_raw  = CNT_W'(r_pos) + CNT_W'(eff_h);
        leave_raw  = CNT_W'(r_pos) + n_minus1 - CNT_W'(eff_h);
        ds_addr    = (ds_raw    >= eff_n) ? ds_raw    - eff_n : ds_raw;
        enter_addr = (enter_raw >= eff_n) ? enter_raw - eff_n : enter_raw;
        leave_addr = (leave_raw >= eff_n) ? leave_raw - eff_n : leave_raw;
    end

    // sample store: one write port, two registered read ports
    logic signed [SAMPLE_W-1:0] r_store [MAX_POINTS];
    logic signed [SAMPLE_W-1:0] r_rd_a;
    logic signed [SAMPLE_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_wr) begin
            r_store[r_load_idx] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ds_rd) begin
            r_rd_a <= r_store[ds_addr[ADDR_W-1:0]];
        end else if (i_cmd.st_rd) begin
            r_rd_a <= r_store[enter_addr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.st_rd) begin
            r_rd_b <= r_store[leave_addr[ADDR_W-1:0]];
        end
    end

    // running window sum, wraps at its width
    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.run_start) begin
            r_sum <= '0;
        end else if (i_cmd.ds_acc) begin
            r_sum <= r_sum + SUM_W'(r_rd_a);
        end else if (i_cmd.st_acc) begin
            r_sum <= r_sum + SUM_W'(r_rd_a) - SUM_W'(r_rd_b);
        end
    end

    // gain multiply, registered
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_sum) * PROD_W'(r_gain);
        end
    end

    // output register; arithmetic shift by 8 is a plain bit-select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else if (i_cmd.put) begin
            o_result_valid <= 1'b1;
        end else if (!i_result_stall) begin
            o_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            o_value <= r_prod[FRAC_W +: VALUE_W];
            o_last  <= o_status.st_last;
        end
    end

endmodule

`default_nettype wire

// ===== design/circular_box_convolution_top.sv =====
`default_nettype none

// Channel   Direction  Handshake                           Payload
// config    in         i_cfg_we                            i_cfg_index, i_cfg_data
// sample    in         i_sample_valid / o_sample_stall     i_sample
// result    out        o_result_valid / i_result_stall     o_value, o_last
//
// Samples transfer one per cycle while loading; the last sample of a run starts emission.
// First window: its 2*h+1 samples are read through one read port and summed one by one
// (h = clamped half width). The first result is then multiplied and loaded into the
// output register; each later one is read, updated, multiplied and loaded.
// Reset (synchronous, active low) restores the register defaults and clears the sum.
// A stalled result holds the output register; samples stall until emission ends.

module circular_box_convolution_top
    import cbc_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                        i_sample_valid,
    output logic                             o_sample_stall,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample,
    output logic                             o_result_valid,
    input  wire logic                        i_result_stall,
    output logic signed [VALUE_W-1:0]        o_value,
    output logic                             o_last
);

    t_cmd    cmd;
    t_status status;

    // sequencing
    cbc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .i_status       (status),
        .o_cmd          (cmd),
        .o_sample_stall (o_sample_stall)
    );

    // store, window sum and scaling
    cbc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_cmd          (cmd),
        .i_result_stall (i_result_stall),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_value        (o_value),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire
